/* rtl/sliding_median_spike_alert_core_defines.svh */
// Assertion macros shared by the sliding median spike alert design.
`ifndef SLIDING_MEDIAN_SPIKE_ALERT_CORE_DEFINES_SVH
`define SLIDING_MEDIAN_SPIKE_ALERT_CORE_DEFINES_SVH
// Checks that an antecedent implies a consequent in the same cycle.
`define SMSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Checks that an antecedent implies a consequent in the next cycle.
`define SMSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* rtl/smsa_pkg.sv */
// Package with types and constants of the sliding median spike alert design.
`timescale 1ns / 1ps
package smsa_pkg;
   localparam int MaxWindowDefault  = 256;
   localparam int SampleBitsDefault = 16;
   localparam int CountBits         = 32;
   localparam int CfgBits           = 9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic update;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
   } status_type;
endpackage

/* rtl/smsa_ctrl.sv */
// Controller state machine that sequences request capture, window update and result.
`timescale 1ns / 1ps
`include "sliding_median_spike_alert_core_defines.svh"
module smsa_ctrl
   import smsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);
   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state. A request is taken in idle or while the last result leaves.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_tready) state_in = req_tvalid ? ST_UPDATE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs. Nothing is accepted while reset is held.
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd.update  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_RESULT: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
         end
         default: ;
      endcase
      if (reset) req_tready = 1'b0;
      cmd.capture = req_tvalid & req_tready;
   end

   `SMSA_ASSERT_NEXT(a_cap_update, clock, reset, cmd.capture, cmd.update, "capture not followed by update")
   `SMSA_ASSERT_NEXT(a_update_rsp, clock, reset, cmd.update, rsp_tvalid, "update not followed by result")
   `SMSA_ASSERT_IMP(a_busy_noready, clock, reset, status.busy, !req_tready, "ready while datapath busy")
endmodule

/* rtl/smsa_datapath.sv */
// Datapath: arrival ring memory, sorted cell chain, median test and alert counter.
`timescale 1ns / 1ps
`include "sliding_median_spike_alert_core_defines.svh"
module smsa_datapath
   import smsa_pkg::*;
#(
   parameter int MAX_WINDOW  = MaxWindowDefault,
   parameter int SAMPLE_BITS = SampleBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CfgBits-1:0]     csr_wdata,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   checked,
   output logic                   alert,
   output logic [SAMPLE_BITS:0]   median_doubled,
   output logic [CountBits-1:0]   alert_count
);
   localparam int PtrBits  = $clog2(MAX_WINDOW);
   localparam int FillBits = $clog2(MAX_WINDOW + 1);
   localparam int CfgW     = (CfgBits > FillBits) ? CfgBits : FillBits;

   logic [CfgBits-1:0]     win_cfg_ff;
   logic [FillBits-1:0]    win_eff;
   logic [FillBits-1:0]    fill_ff;
   logic [PtrBits-1:0]     ptr_ff;
   logic [CountBits-1:0]   total_ff;
   logic [SAMPLE_BITS-1:0] samp_ff;
   logic [SAMPLE_BITS-1:0] old_rd_ff;
   logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] cell_ff [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] cell_next [MAX_WINDOW];
   logic                   full_ff;
   logic                   checked_ff, alert_ff;
   logic [SAMPLE_BITS:0]   dbl_ff;
   logic [PtrBits-1:0]     rd_addr;
   logic [SAMPLE_BITS:0]   dbl_now;
   logic [FillBits-1:0]    half;

   // Clamp the programmed window into one to the maximum.
   always_comb begin
      logic [CfgW-1:0] wc;
      wc = CfgW'(win_cfg_ff);
      if (wc == '0) win_eff = FillBits'(1);
      else if (wc > CfgW'(MAX_WINDOW)) win_eff = FillBits'(MAX_WINDOW);
      else win_eff = FillBits'(wc);
   end

   // Ring slot read at capture: the oldest sample when the window is full.
   assign rd_addr = (ptr_ff >= PtrBits'(win_eff - FillBits'(1)) + PtrBits'(1)
                     && win_eff != FillBits'(MAX_WINDOW)) ? '0 : ptr_ff;
   assign status.busy = 1'b0;

   // Ring memory: registered read at capture, write in the update cycle.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_ff   <= sample;
         old_rd_ff <= ring_mem[rd_addr];
      end
      if (cmd.update) begin
         ring_mem[full_ff ? rd_addr : PtrBits'(fill_ff)] <= samp_ff;
      end
   end

   // Median of the current window, taken from fixed cells.
   assign half = win_eff >> 1;
   always_comb begin
      if (win_eff[0]) begin
         dbl_now = {cell_ff[half[PtrBits-1:0]], 1'b0};
      end else begin
         dbl_now = {1'b0, cell_ff[PtrBits'(half - FillBits'(1))]}
                 + {1'b0, cell_ff[half[PtrBits-1:0]]};
      end
   end

   // Next chain contents: drop the oldest sample when full, then insert the new one.
   always_comb begin
      logic [SAMPLE_BITS-1:0] c [MAX_WINDOW];
      logic                   rm [MAX_WINDOW];
      logic                   found;
      logic                   gt_here, gt_below;
      logic [FillBits-1:0]    n;
      c = cell_ff;
      n = full_ff ? win_eff - FillBits'(1) : fill_ff;
      // The removal mask marks positions at or after the removed entry.
      found = 1'b0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (full_ff && FillBits'(k) < win_eff && c[k] == old_rd_ff) found = 1'b1;
         if (full_ff && FillBits'(k) == win_eff - FillBits'(1)) found = 1'b1;
         rm[k] = found;
      end
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (rm[k] && k + 1 < MAX_WINDOW) c[k] = cell_ff[(k + 1) % MAX_WINDOW];
      end
      // Entries above the sample shift up by one within the first n cells.
      for (int k = 0; k < MAX_WINDOW; k++) begin
         gt_here  = FillBits'(k) < n && c[k] > samp_ff;
         gt_below = (k > 0) && FillBits'(k - 1) < n
                    && c[(k + MAX_WINDOW - 1) % MAX_WINDOW] > samp_ff;
         if (FillBits'(k) > n) cell_next[k] = c[k];
         else if (gt_below) cell_next[k] = c[(k + MAX_WINDOW - 1) % MAX_WINDOW];
         else if (gt_here || FillBits'(k) == n) cell_next[k] = samp_ff;
         else cell_next[k] = c[k];
      end
   end

   // Sorted cell chain: one insert per update, after one remove once the window is full.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         cell_ff <= cell_next;
      end
   end

   // Control state of the window and the result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff <= CfgBits'(1);
         fill_ff    <= '0;
         ptr_ff     <= '0;
         full_ff    <= 1'b0;
         total_ff   <= '0;
         checked_ff <= 1'b0;
         alert_ff   <= 1'b0;
         dbl_ff     <= '0;
      end else if (csr_we) begin
         win_cfg_ff <= csr_wdata;
         fill_ff    <= '0;
         ptr_ff     <= '0;
         full_ff    <= 1'b0;
      end else if (cmd.update) begin
         if (!full_ff) begin
            checked_ff <= 1'b0;
            alert_ff   <= 1'b0;
            dbl_ff     <= '0;
            fill_ff    <= fill_ff + FillBits'(1);
            if (fill_ff + FillBits'(1) >= win_eff) full_ff <= 1'b1;
         end else begin
            checked_ff <= 1'b1;
            dbl_ff     <= dbl_now;
            alert_ff   <= ({1'b0, samp_ff} >= dbl_now);
            if ({1'b0, samp_ff} >= dbl_now && total_ff != '1) total_ff <= total_ff + 1'b1;
            if (FillBits'(rd_addr) + FillBits'(1) >= win_eff) ptr_ff <= '0;
            else ptr_ff <= rd_addr + PtrBits'(1);
         end
      end
   end

   assign checked        = checked_ff;
   assign alert          = alert_ff;
   assign median_doubled = dbl_ff;
   assign alert_count    = total_ff;

   `SMSA_ASSERT_IMP(a_alert_chk, clock, reset, alert_ff, checked_ff, "alert without check")
   `SMSA_ASSERT_IMP(a_fill_range, clock, reset, !full_ff, fill_ff < win_eff || csr_we, "fill overrun")
   `SMSA_ASSERT_IMP(a_ptr_range, clock, reset, full_ff, FillBits'(ptr_ff) < win_eff, "pointer outside window")
endmodule

/* rtl/sliding_median_spike_alert_core.sv */
// Top level of the sliding median spike alert core.
`timescale 1ns / 1ps
// Each request carries one sample and yields one response: the sample is
// captured with a ring read when taken, then the sorted chain is updated,
// then the response is offered. A new request is accepted in the cycle its
// predecessor's response is taken. The first window_len samples after reset
// or a csr write only fill the window and are reported unchecked.
module sliding_median_spike_alert_core
   import smsa_pkg::*;
#(
   parameter int MAX_WINDOW  = MaxWindowDefault,
   parameter int SAMPLE_BITS = SampleBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CfgBits-1:0]   csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // checked, alert, median_doubled, alert_count
   output logic [((SAMPLE_BITS+35+7)/8)*8-1:0] rsp_tdata
);
   localparam int RspBits = ((SAMPLE_BITS + 35 + 7) / 8) * 8;
   cmd_type    cmd;
   status_type status;
   logic checked, alert;
   logic [SAMPLE_BITS:0] dbl;
   logic [CountBits-1:0] cnt;

   smsa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .cmd(cmd), .status(status)
   );

   smsa_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .sample(req_tdata[SAMPLE_BITS-1:0]), .cmd(cmd), .status(status),
      .checked(checked), .alert(alert), .median_doubled(dbl), .alert_count(cnt)
   );

   // Pack the response fields from the lowest bit up.
   assign rsp_tdata = RspBits'({cnt, dbl, alert, checked});
endmodule

/* verif/testbench.sv */
// Self-checking testbench for the sliding median spike alert core.
`timescale 1ns / 1ps
module testbench;
   import smsa_pkg::*;

   localparam int Window = MaxWindowDefault;

   // Result fields as packed in rsp_tdata, lowest bit last in this list.
   typedef struct packed {
      logic [CountBits-1:0] alert_count;
      logic [16:0]          median_doubled;
      logic                 alert;
      logic                 checked;
   } spike_result_t;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [8:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   // Predictor state.
   logic [15:0]          arrival_q[Window];
   logic [15:0]          sorted_q[Window];
   int                   fill_count;
   int                   oldest_slot;
   logic [CountBits-1:0] alert_sum;
   logic [8:0]           window_reg;

   spike_result_t pending_results[$];
   int            fail_count;
   bit            idle_enable;
   int            rsp_hold;
   int            rsp_gap;

   sliding_median_spike_alert_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Inserts a value into the first count entries of the sorted store.
   function automatic void sorted_put(int count, logic [15:0] v);
      int j;
      j = count;
      while (j > 0 && sorted_q[j-1] > v) begin
         sorted_q[j] = sorted_q[j-1];
         j--;
      end
      sorted_q[j] = v;
   endfunction

   // Removes one entry equal to v from the first count entries.
   function automatic void sorted_drop(int count, logic [15:0] v);
      int k;
      k = 0;
      while (k < count && sorted_q[k] != v) k++;
      if (k >= count) k = count - 1;
      while (k + 1 < count) begin
         sorted_q[k] = sorted_q[k+1];
         k++;
      end
   endfunction

   // Computes the response for one sample and advances the predictor.
   function automatic spike_result_t predict_spike(logic [15:0] s);
      spike_result_t r;
      int            w;
      int            half;
      logic [15:0]   old;
      r = '0;
      w = (window_reg == 0) ? 1 : ((window_reg > Window) ? Window : int'(window_reg));
      if (fill_count < w) begin
         arrival_q[fill_count] = s;
         sorted_put(fill_count, s);
         fill_count++;
      end else begin
         half = w / 2;
         if (w % 2 == 1) r.median_doubled = {1'b0, sorted_q[half]} << 1;
         else r.median_doubled = {1'b0, sorted_q[half-1]} + {1'b0, sorted_q[half]};
         r.checked = 1'b1;
         if ({1'b0, s} >= r.median_doubled) begin
            r.alert = 1'b1;
            if (alert_sum != '1) alert_sum++;
         end
         if (oldest_slot >= w) oldest_slot = 0;
         old = arrival_q[oldest_slot];
         sorted_drop(w, old);
         sorted_put(w - 1, s);
         arrival_q[oldest_slot] = s;
         oldest_slot++;
         if (oldest_slot >= w) oldest_slot = 0;
      end
      r.alert_count = alert_sum;
      return r;
   endfunction

   // Sends one sample request and records its expected response.
   task automatic send_sample(logic [15:0] s);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      pending_results = {pending_results, predict_spike(s)};
   endtask

   // Stops sending and waits until every expected response has arrived.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Waits for all responses, then writes the window length.
   task automatic write_window(logic [8:0] v);
      drain_responses();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we      <= 1'b0;
      window_reg  = v;
      fill_count  = 0;
      oldest_slot = 0;
   endtask

   // Random sample: mostly a quiet baseline, some spikes, some full range.
   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(1500, 4000));
         default: return 16'($urandom_range(0, 1000));
      endcase
   endfunction

   // Receiver: random stall bursts and an optional long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Response checker against the oldest expected result.
   always @(posedge clock) begin
      spike_result_t got;
      spike_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[50:0];
         if (pending_results.size() == 0) begin
            $error("unexpected response %h", got);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.checked !== want.checked) begin
               $error("checked: expected %0d actual %0d", want.checked, got.checked);
               fail_count++;
            end
            if (got.alert !== want.alert) begin
               $error("alert: expected %0d actual %0d", want.alert, got.alert);
               fail_count++;
            end
            if (got.median_doubled !== want.median_doubled) begin
               $error("median_doubled: expected %0d actual %0d",
                      want.median_doubled, got.median_doubled);
               fail_count++;
            end
            if (got.alert_count !== want.alert_count) begin
               $error("alert_count: expected %0d actual %0d",
                      want.alert_count, got.alert_count);
               fail_count++;
            end
         end
      end
   end

   // Window of one, sample extremes.
   task automatic test_single_window();
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h7FFF);
      send_sample(16'hFFFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
   endtask

   // Window of zero, even and odd small windows.
   task automatic test_small_windows();
      write_window(9'd0);
      send_sample(16'd10);
      send_sample(16'd20);
      send_sample(16'd40);
      write_window(9'd2);
      send_sample(16'd5);
      send_sample(16'd7);
      send_sample(16'd12);
      send_sample(16'd11);
      send_sample(16'hFFFF);
      write_window(9'd3);
      send_sample(16'd4);
      send_sample(16'd4);
      send_sample(16'd4);
      send_sample(16'd8);
      send_sample(16'd7);
   endtask

   // Random samples at several window lengths.
   task automatic test_random_windows();
      write_window(9'd4);
      repeat (30) send_sample(random_sample());
      write_window(9'd5);
      repeat (20) send_sample(random_sample());
      write_window(9'($urandom_range(6, 20)));
      repeat (30) send_sample(random_sample());
   endtask

   // A length above the maximum, which acts as the longest window.
   task automatic test_long_windows();
      write_window(9'd511);
      repeat (270) send_sample(random_sample());
   endtask

   // Receiver holds off while requests keep coming; then the sender pauses.
   task automatic test_backpressure();
      write_window(9'd3);
      rsp_hold = 80;
      repeat (20) send_sample(random_sample());
      drain_responses();
      repeat (10) send_sample(random_sample());
   endtask

   initial begin
      reset       <= 1'b1;
      csr_we      <= 1'b0;
      csr_wdata   <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      fill_count  = 0;
      oldest_slot = 0;
      alert_sum   = '0;
      window_reg  = 9'd1;
      fail_count  = 0;
      idle_enable = 1'b1;
      rsp_hold    = 0;
      rsp_gap     = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_window();
      test_small_windows();
      test_random_windows();
      test_long_windows();
      test_backpressure();
      // Final stretch without idling.
      idle_enable = 1'b0;
      rsp_gap     = 0;
      write_window(9'd7);
      repeat (20) send_sample(random_sample());
      drain_responses();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
